// ----- src/npct_pkg.sv -----
// shared types, codes and constants for the port connection table
`timescale 1ns / 1ps
package npct_pkg;

  // table geometry and register reset values
  localparam int          SLOTS_DEF     = 256;
  localparam logic [15:0] PORT_BASE_RST = 16'd10000;
  localparam logic [10:0] TIMEOUT_RST   = 11'd5;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  // configuration register indexes
  localparam logic [1:0] CFG_PORT_BASE = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd1;

  // result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_MISS = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOOKUP    = 2'd0,
    CMD_DELETE    = 2'd1,
    CMD_TRANSLATE = 2'd2,
    CMD_SWEEP     = 2'd3
  } cmd_e_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_RD,
    S_LK_EV,
    S_ALLOC,
    S_POP_WAIT,
    S_CREATE,
    S_DEL_RD,
    S_DEL_EV,
    S_TR_RD,
    S_TR_EV,
    S_SW_RD,
    S_SW_EV,
    S_DONE
  } fsm_t;

  typedef struct packed {
    cmd_e_t      command;
    logic [15:0] session;
    logic [15:0] port;
    logic [7:0]  entry;
    logic [31:0] now;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [15:0] public_port;
    logic        was_created;
    logic [15:0] owner_session;
    logic [15:0] client_port;
    logic        entry_active;
    logic [8:0]  removed_count;
  } out_rsp_t;

  // one connection entry as held in the entry memory
  typedef struct packed {
    logic [15:0] owner;
    logic [15:0] cport;
    logic [31:0] stamp;
  } ent_t;

  // match and age flags for the entry just read
  typedef struct packed {
    logic hit;
    logic old;
  } probe_t;

endpackage

// ----- src/nat_port_connection_table.sv -----
// top level of the port connection table: command sequencer and registers
`timescale 1ns / 1ps
// Port translation connection table.
// Input channel in_req (valid/stall) carries one command: lookup_or_create,
// delete, translate or age sweep. Each command gives one result on out_rsp
// (valid/stall). Configuration writes on cfg_* (valid/ready, always ready)
// set port_base (index 0) and timeout_minutes (index 1); write them only
// while the table is idle.
// Commands run one at a time; entries live in a one-port-read memory with
// a registered read, so scans visit each slot in a read state and then
// an evaluate state. A lookup stops at the first hit, else scans every slot
// below the high-water mark; delete and translate skip the evaluate state
// when out of range; an age sweep scans up to the high-water mark.
// The next request is taken once the previous command has left its result
// in the output register, so a waiting result does not block intake. If the
// receiver stalls and a second result is ready, the sequencer holds in its
// done state until the output register frees.
// Reset (rst_n, synchronous) clears active marks, free count and high-water
// mark at once; there is no clearing pass, and registers return to
// port_base 10000 and timeout 5 minutes.
module nat_port_connection_table #(
  parameter int SLOTS = npct_pkg::SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  npct_pkg::in_req_t in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output npct_pkg::out_rsp_t out_rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import npct_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  fsm_t          state_r, state_nxt;
  in_req_t       req_r, req_nxt;
  out_rsp_t      res_r, res_nxt;
  out_rsp_t      out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] hw_r, hw_nxt;
  logic [8:0]    removed_r, removed_nxt;
  logic [SW-1:0] new_slot_r, new_slot_nxt;
  logic [15:0]   port_base_r;
  logic [10:0]   timeout_r;

  logic          in_accept;
  logic          out_free;
  logic [16:0]   age_limit;
  logic [15:0]   tr_slot;
  logic          del_ok, tr_ok, scan_ok, hw_room;

  logic [SW-1:0] rd_addr;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  ent_t          wr_data;
  logic          act_set, act_clr;
  logic [SW-1:0] act_addr;
  ent_t          rd_data;
  logic          rd_active;
  probe_t        probe;

  logic          fs_push, fs_pop, fs_empty, fs_full;
  logic [SW-1:0] fs_pop_slot;
  logic          rm_en;
  logic [CW-1:0] rm_slot;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign age_limit = {6'd0, timeout_r} * SECS_PER_MIN;
  assign tr_slot   = req_r.port - port_base_r;
  assign del_ok    = 32'(req_r.entry) < 32'(hw_r);
  assign tr_ok     = 32'(tr_slot) < 32'(hw_r);
  assign scan_ok   = idx_r < hw_r;
  assign hw_room   = hw_r < CW'(SLOTS);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_base_r <= PORT_BASE_RST;
      timeout_r   <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PORT_BASE: port_base_r <= cfg_data;
        CFG_TIMEOUT:   timeout_r   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_req.command)
            CMD_LOOKUP:    state_nxt = S_LK_RD;
            CMD_DELETE:    state_nxt = S_DEL_RD;
            CMD_TRANSLATE: state_nxt = S_TR_RD;
            default:       state_nxt = S_SW_RD;
          endcase
        end
      end
      S_LK_RD:    state_nxt = scan_ok ? S_LK_EV : S_ALLOC;
      S_LK_EV:    state_nxt = probe.hit ? S_DONE : S_LK_RD;
      S_ALLOC: begin
        if (!fs_empty) begin
          state_nxt = S_POP_WAIT;
        end else if (hw_room) begin
          state_nxt = S_CREATE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POP_WAIT: state_nxt = S_CREATE;
      S_CREATE:   state_nxt = S_DONE;
      S_DEL_RD:   state_nxt = del_ok ? S_DEL_EV : S_DONE;
      S_DEL_EV:   state_nxt = S_DONE;
      S_TR_RD:    state_nxt = tr_ok ? S_TR_EV : S_DONE;
      S_TR_EV:    state_nxt = S_DONE;
      S_SW_RD:    state_nxt = scan_ok ? S_SW_EV : S_DONE;
      S_SW_EV:    state_nxt = S_SW_RD;
      S_DONE:     state_nxt = out_free ? S_IDLE : S_DONE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control per state
  always_comb begin
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    hw_nxt        = hw_r;
    removed_nxt   = removed_r;
    new_slot_nxt  = new_slot_r;
    rd_addr       = idx_r[SW-1:0];
    wr_en         = 1'b0;
    wr_addr       = idx_r[SW-1:0];
    wr_data       = '{owner: req_r.session, cport: req_r.port, stamp: req_r.now};
    act_set       = 1'b0;
    act_clr       = 1'b0;
    act_addr      = idx_r[SW-1:0];
    fs_push       = 1'b0;
    fs_pop        = 1'b0;
    rm_en         = 1'b0;
    rm_slot       = idx_r;

    // output register drains when taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          req_nxt     = in_req;
          res_nxt     = '0;
          idx_nxt     = '0;
          removed_nxt = '0;
        end
      end
      S_LK_RD: ;
      S_LK_EV: begin
        if (probe.hit) begin
          wr_en               = 1'b1;
          res_nxt.slot        = 8'(idx_r);
          res_nxt.public_port = port_base_r + 16'(idx_r);
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_ALLOC: begin
        if (!fs_empty) begin
          fs_pop = 1'b1;
        end else if (hw_room) begin
          new_slot_nxt = hw_r[SW-1:0];
          hw_nxt       = hw_r + CW'(1);
        end else begin
          res_nxt.status = STAT_FULL;
        end
      end
      S_POP_WAIT: new_slot_nxt = fs_pop_slot;
      S_CREATE: begin
        wr_en               = 1'b1;
        wr_addr             = new_slot_r;
        act_set             = 1'b1;
        act_addr            = new_slot_r;
        res_nxt.slot        = 8'(new_slot_r);
        res_nxt.public_port = port_base_r + 16'(new_slot_r);
        res_nxt.was_created = 1'b1;
      end
      S_DEL_RD: begin
        rd_addr = SW'(req_r.entry);
        if (!del_ok) begin
          res_nxt.status = STAT_MISS;
        end
      end
      S_DEL_EV: begin
        if (rd_active) begin
          rm_en               = 1'b1;
          rm_slot             = CW'(req_r.entry);
          res_nxt.slot        = req_r.entry;
          res_nxt.public_port = port_base_r + 16'(req_r.entry);
        end else begin
          res_nxt.status = STAT_MISS;
        end
      end
      S_TR_RD: begin
        rd_addr = SW'(tr_slot);
        if (!tr_ok) begin
          res_nxt.status = STAT_MISS;
        end
      end
      S_TR_EV: begin
        res_nxt.slot          = tr_slot[7:0];
        res_nxt.public_port   = req_r.port;
        res_nxt.owner_session = rd_data.owner;
        res_nxt.client_port   = rd_data.cport;
        res_nxt.entry_active  = rd_active;
      end
      S_SW_RD: begin
        if (!scan_ok) begin
          res_nxt.removed_count = removed_r;
        end
      end
      S_SW_EV: begin
        if (probe.old) begin
          rm_en       = 1'b1;
          removed_nxt = removed_r + 9'd1;
        end
        idx_nxt = idx_r + CW'(1);
      end
      S_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    // slot removal: lower high-water on the top slot, else push it free
    if (rm_en) begin
      act_clr  = 1'b1;
      act_addr = rm_slot[SW-1:0];
      if (rm_slot + CW'(1) == hw_r) begin
        hw_nxt = hw_r - CW'(1);
      end else begin
        fs_push = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hw_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hw_r        <= hw_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
    idx_r      <= idx_nxt;
    removed_r  <= removed_nxt;
    new_slot_r <= new_slot_nxt;
  end

  npct_entry_store #(
    .SLOTS(SLOTS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .act_set    (act_set),
    .act_clr    (act_clr),
    .act_addr   (act_addr),
    .key_session(req_r.session),
    .key_port   (req_r.port),
    .now        (req_r.now),
    .age_limit  (age_limit),
    .rd_data    (rd_data),
    .rd_active  (rd_active),
    .probe      (probe)
  );

  npct_free_stack #(
    .SLOTS(SLOTS)
  ) u_free (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fs_push),
    .push_slot(rm_slot[SW-1:0]),
    .pop      (fs_pop),
    .pop_slot (fs_pop_slot),
    .empty    (fs_empty),
    .full     (fs_full)
  );

`ifndef ASSERT_OFF
  // high-water mark never passes the table size
  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= CW'(SLOTS))
    else $error("high-water mark beyond table size");

  // a result appears only from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside done state");

  // the free stack is popped only when it holds a slot
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fs_pop |-> !fs_empty)
    else $error("pop from empty free stack");

  // a freed slot always finds room on the stack
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    fs_push |-> !fs_full)
    else $error("push to full free stack");
`endif

endmodule

// ----- src/npct_entry_store.sv -----
// connection entry memory with active marks, match and age checks
`timescale 1ns / 1ps
module npct_entry_store #(
  parameter int SLOTS = npct_pkg::SLOTS_DEF,
  localparam int SW = $clog2(SLOTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [SW-1:0]     wr_addr,
  input  npct_pkg::ent_t    wr_data,
  input  logic              act_set,
  input  logic              act_clr,
  input  logic [SW-1:0]     act_addr,
  input  logic [15:0]       key_session,
  input  logic [15:0]       key_port,
  input  logic [31:0]       now,
  input  logic [16:0]       age_limit,
  output npct_pkg::ent_t    rd_data,
  output logic              rd_active,
  output npct_pkg::probe_t  probe
);
  import npct_pkg::*;

  ent_t             mem [SLOTS];
  logic [SLOTS-1:0] active_r;
  logic [31:0]      age;

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // active marks, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      rd_active <= 1'b0;
    end else begin
      if (act_set) begin
        active_r[act_addr] <= 1'b1;
      end else if (act_clr) begin
        active_r[act_addr] <= 1'b0;
      end
      rd_active <= active_r[rd_addr];
    end
  end

  // match and age test on the entry read last cycle
  always_comb begin
    age       = now - rd_data.stamp;
    probe.hit = rd_active && (rd_data.owner == key_session) && (rd_data.cport == key_port);
    probe.old = rd_active && (age >= {15'd0, age_limit});
  end

endmodule

// ----- src/npct_free_stack.sv -----
// free slot stack in memory with its fill count
`timescale 1ns / 1ps
module npct_free_stack #(
  parameter int SLOTS = npct_pkg::SLOTS_DEF,
  localparam int SW = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [SW-1:0] push_slot,
  input  logic          pop,
  output logic [SW-1:0] pop_slot,
  output logic          empty,
  output logic          full
);
  import npct_pkg::*;

  logic [SW-1:0] mem [SLOTS];
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] top_idx;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(SLOTS));
  assign top_idx = count_r - CW'(1);

  // fill count
  always_comb begin
    count_nxt = count_r;
    if (push && !full) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !empty) begin
      count_nxt = top_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // stack memory, top read registered on pop
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[count_r[SW-1:0]] <= push_slot;
    end
    if (pop) begin
      pop_slot <= mem[top_idx[SW-1:0]];
    end
  end

endmodule
